>>> hw/rtl/fast_inverse_sqrt_double_macros.svh
// Assertion macros for the checker file of the reciprocal square root block.
// The macros expect signals named clk and arst_n in the scope where they are used.
`ifndef FAST_INVERSE_SQRT_DOUBLE_MACROS_SVH
`define FAST_INVERSE_SQRT_DOUBLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FISD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FISD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/fisd_pkg.sv
// Package for the reciprocal square root block: binary64 layout, constants, helpers.
// Used by the multiplier, the subtractor and the top level; depends on nothing.
package fisd_pkg;

	typedef struct packed {
		logic        sign;
		logic [10:0] exp;
		logic [51:0] frac;
	} fp64_t;

	localparam logic [63:0] MAGIC    = 64'h5fe6eb50c7b537a9;
	localparam logic [63:0] FP_HALF  = 64'h3fe0000000000000;
	localparam logic [63:0] FP_THREE_HALVES = 64'h3ff8000000000000;
	localparam logic [63:0] DEFAULT_NAN = 64'hfff8000000000000;
	localparam logic [10:0] EXP_MAX  = 11'h7ff;

	function automatic logic [5:0] clz53(input logic [52:0] m);
		logic [5:0] n;
		n = 6'd53;
		for (int i = 0; i < 53; i++) begin
			if (m[i]) begin
				n = 6'(52 - i);
			end
		end
		return n;
	endfunction

	function automatic logic [5:0] clz56(input logic [55:0] m);
		logic [5:0] n;
		n = 6'd56;
		for (int i = 0; i < 56; i++) begin
			if (m[i]) begin
				n = 6'(55 - i);
			end
		end
		return n;
	endfunction

	function automatic logic is_nan(input fp64_t f);
		return (f.exp == EXP_MAX) && (f.frac != 52'd0);
	endfunction

	function automatic logic is_inf(input fp64_t f);
		return (f.exp == EXP_MAX) && (f.frac == 52'd0);
	endfunction

	function automatic logic [63:0] quiet(input fp64_t f);
		return {f.sign, EXP_MAX, 1'b1, f.frac[50:0]};
	endfunction

endpackage

>>> hw/rtl/fast_inverse_sqrt_double.sv
// Approximate reciprocal square root of binary64 values, one Newton step, fully pipelined.
// Instantiates fisd_fmul and fisd_fsub; depends on fisd_pkg for constants.
//
// Usage: each transfer on the s_axis side carries one binary64 bit pattern; the
// m_axis side returns one binary64 bit pattern per input, in order. The first
// guess is the magic constant minus the input shifted right arithmetically by
// one; the result is y * (1.5 - ((x * 0.5) * y) * y), every operation rounded
// to nearest even with full IEEE handling of subnormals, infinities and NaNs.
// An input transfer reaches m_axis_tdata through a chain of four 4-stage
// multipliers and one 5-stage subtractor. Throughput is one transfer per cycle
// while m_axis_tready is high. Each stage holds a valid bit and its own ready, so a
// stall on m_axis_tready fills bubbles first and holds s_axis_tready high until
// the pipeline is full; nothing is dropped or repeated. Reset empties the
// pipeline; no result is shown until a new input arrives.
module fast_inverse_sqrt_double (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [63:0] value_bits
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata   // [63:0] rsqrt_bits
);
	logic [63:0] guess;
	logic half_valid, half_ready, t_valid, t_ready, sq_valid, sq_ready, corr_valid, corr_ready;
	logic [63:0] half_val, half_side, t_val, t_side, sq_val, sq_side, corr_val, corr_side;
	logic [63:0] r_side;

	assign guess = fisd_pkg::MAGIC - {s_axis_tdata[63], s_axis_tdata[63:1]};

	fisd_fmul u_mul_half (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.a(s_axis_tdata), .b(fisd_pkg::FP_HALF), .side(guess),
		.out_valid(half_valid), .out_ready(half_ready),
		.result(half_val), .side_out(half_side)
	);

	fisd_fmul u_mul_t (
		.clk(clk), .arst_n(arst_n),
		.in_valid(half_valid), .in_ready(half_ready),
		.a(half_val), .b(half_side), .side(half_side),
		.out_valid(t_valid), .out_ready(t_ready),
		.result(t_val), .side_out(t_side)
	);

	fisd_fmul u_mul_sq (
		.clk(clk), .arst_n(arst_n),
		.in_valid(t_valid), .in_ready(t_ready),
		.a(t_val), .b(t_side), .side(t_side),
		.out_valid(sq_valid), .out_ready(sq_ready),
		.result(sq_val), .side_out(sq_side)
	);

	fisd_fsub u_sub_corr (
		.clk(clk), .arst_n(arst_n),
		.in_valid(sq_valid), .in_ready(sq_ready),
		.a(fisd_pkg::FP_THREE_HALVES), .b(sq_val), .side(sq_side),
		.out_valid(corr_valid), .out_ready(corr_ready),
		.result(corr_val), .side_out(corr_side)
	);

	fisd_fmul u_mul_r (
		.clk(clk), .arst_n(arst_n),
		.in_valid(corr_valid), .in_ready(corr_ready),
		.a(corr_side), .b(corr_val), .side(corr_side),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.result(m_axis_tdata), .side_out(r_side)
	);

endmodule

>>> hw/rtl/fisd_fmul.sv
// Four-stage pipelined binary64 multiplier, round to nearest even, with a side word.
// Depends on fisd_pkg for the binary64 layout and helper functions.
module fisd_fmul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic [63:0] side,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result,
	output logic [63:0] side_out
);
	fisd_pkg::fp64_t ua, ub;
	logic a_zero, b_zero, spec_c, sign_c;
	logic [63:0] sval_c;
	logic [52:0] ma, mb;
	logic [5:0] lz_a, lz_b;
	logic [10:0] ea, eb;
	logic signed [13:0] esum_c;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic spec_s1, sign_s1;
	logic [63:0] sval_s1, side_s1;
	logic [52:0] man_a_s1, man_b_s1;
	logic signed [13:0] esum_s1;

	logic spec_s2, sign_s2;
	logic [63:0] sval_s2, side_s2;
	logic signed [13:0] esum_s2;
	logic [51:0] pp_hh_s2;
	logic [52:0] pp_hl_s2, pp_lh_s2;
	logic [53:0] pp_ll_s2;

	logic spec_s3, sign_s3;
	logic [63:0] sval_s3, side_s3;
	logic signed [13:0] esum_s3;
	logic [105:0] prod_s3;

	logic [63:0] res_s4, side_s4;

	logic signed [13:0] e_n, tmp;
	logic [105:0] m_n, m_x;
	logic [6:0] sh;
	logic lost, rnd;
	logic [10:0] ef;
	logic [62:0] mag;
	logic [63:0] res_c;

	assign rdy_s4 = !v_s4 || out_ready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign out_valid = v_s4;
	assign result = res_s4;
	assign side_out = side_s4;

	always_comb begin
		ua = fisd_pkg::fp64_t'(a);
		ub = fisd_pkg::fp64_t'(b);
		a_zero = (ua.exp == 11'd0) && (ua.frac == 52'd0);
		b_zero = (ub.exp == 11'd0) && (ub.frac == 52'd0);
		sign_c = ua.sign ^ ub.sign;
		spec_c = 1'b1;
		if (fisd_pkg::is_nan(ua)) begin
			sval_c = fisd_pkg::quiet(ua);
		end else if (fisd_pkg::is_nan(ub)) begin
			sval_c = fisd_pkg::quiet(ub);
		end else if ((fisd_pkg::is_inf(ua) && b_zero) || (a_zero && fisd_pkg::is_inf(ub))) begin
			sval_c = fisd_pkg::DEFAULT_NAN;
		end else if (fisd_pkg::is_inf(ua) || fisd_pkg::is_inf(ub)) begin
			sval_c = {sign_c, fisd_pkg::EXP_MAX, 52'd0};
		end else if (a_zero || b_zero) begin
			sval_c = {sign_c, 63'd0};
		end else begin
			sval_c = 64'd0;
			spec_c = 1'b0;
		end
		ma = {ua.exp != 11'd0, ua.frac};
		mb = {ub.exp != 11'd0, ub.frac};
		ea = (ua.exp == 11'd0) ? 11'd1 : ua.exp;
		eb = (ub.exp == 11'd0) ? 11'd1 : ub.exp;
		lz_a = fisd_pkg::clz53(ma);
		lz_b = fisd_pkg::clz53(mb);
		esum_c = $signed({3'b000, ea}) + $signed({3'b000, eb})
			- $signed({8'd0, lz_a}) - $signed({8'd0, lz_b}) - 14'sd1022;
	end

	always_comb begin
		if (prod_s3[105]) begin
			m_n = prod_s3;
			e_n = esum_s3;
		end else begin
			m_n = {prod_s3[104:0], 1'b0};
			e_n = esum_s3 - 14'sd1;
		end
		tmp = 14'sd1 - e_n;
		if (e_n <= 14'sd0) begin
			sh = (tmp > 14'sd127) ? 7'd127 : tmp[6:0];
			m_x = m_n >> sh;
			lost = |(m_n & ((106'd1 << sh) - 106'd1));
			ef = 11'd0;
		end else begin
			sh = 7'd0;
			m_x = m_n;
			lost = 1'b0;
			ef = e_n[10:0];
		end
		rnd = m_x[52] && ((|m_x[51:0]) || lost || m_x[53]);
		mag = {ef, m_x[104:53]} + 63'(rnd);
		if (spec_s3) begin
			res_c = sval_s3;
		end else if (e_n >= 14'sd2047) begin
			res_c = {sign_s3, fisd_pkg::EXP_MAX, 52'd0};
		end else begin
			res_c = {sign_s3, mag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			spec_s1  <= spec_c;
			sval_s1  <= sval_c;
			sign_s1  <= sign_c;
			side_s1  <= side;
			man_a_s1 <= ma << lz_a;
			man_b_s1 <= mb << lz_b;
			esum_s1  <= esum_c;
		end
		if (rdy_s2) begin
			spec_s2  <= spec_s1;
			sval_s2  <= sval_s1;
			sign_s2  <= sign_s1;
			side_s2  <= side_s1;
			esum_s2  <= esum_s1;
			pp_hh_s2 <= man_a_s1[52:27] * man_b_s1[52:27];
			pp_hl_s2 <= man_a_s1[52:27] * man_b_s1[26:0];
			pp_lh_s2 <= man_a_s1[26:0] * man_b_s1[52:27];
			pp_ll_s2 <= man_a_s1[26:0] * man_b_s1[26:0];
		end
		if (rdy_s3) begin
			spec_s3 <= spec_s2;
			sval_s3 <= sval_s2;
			sign_s3 <= sign_s2;
			side_s3 <= side_s2;
			esum_s3 <= esum_s2;
			prod_s3 <= {pp_hh_s2, 54'd0} + 106'({pp_hl_s2, 27'd0})
				+ 106'({pp_lh_s2, 27'd0}) + 106'(pp_ll_s2);
		end
		if (rdy_s4) begin
			res_s4  <= res_c;
			side_s4 <= side_s3;
		end
	end

endmodule

>>> hw/rtl/fisd_fsub.sv
// Five-stage pipelined binary64 subtractor a - b, round to nearest even, with a side word.
// Depends on fisd_pkg for the binary64 layout and helper functions.
module fisd_fsub (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic [63:0] side,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result,
	output logic [63:0] side_out
);
	fisd_pkg::fp64_t ua, ub;
	logic sbn, spec_c, a_big, sign_c;
	logic [63:0] sval_c;
	logic [10:0] exp_l, exp_s, e_l, e_s, d;
	logic [51:0] frac_l, frac_s;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	logic spec_s1, sign_s1, sub_s1;
	logic [63:0] sval_s1, side_s1;
	logic [10:0] ea_s1;
	logic [52:0] ma_s1, mb_s1;
	logic [5:0] d_s1;

	logic spec_s2, sign_s2, sub_s2;
	logic [63:0] sval_s2, side_s2;
	logic [10:0] ea_s2;
	logic [52:0] ma_s2;
	logic [55:0] mb_s2;

	logic spec_s3, sign_s3, sub_s3;
	logic [63:0] sval_s3, side_s3;
	logic [10:0] ea_s3;
	logic [56:0] sum_s3;

	logic spec_s4, sign_s4, sub_s4, zero_s4;
	logic [63:0] sval_s4, side_s4;
	logic [11:0] e_s4;
	logic [55:0] n_s4;

	logic [63:0] res_s5, side_s5;

	logic [55:0] bw, al, lost_mask;
	logic [5:0] lz, shamt;
	logic [10:0] lim;
	logic [55:0] n_c;
	logic [11:0] e_c;
	logic [10:0] field;
	logic rnd;
	logic [62:0] mag;
	logic [63:0] res_c;

	assign rdy_s5 = !v_s5 || out_ready;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign out_valid = v_s5;
	assign result = res_s5;
	assign side_out = side_s5;

	always_comb begin
		ua = fisd_pkg::fp64_t'(a);
		ub = fisd_pkg::fp64_t'(b);
		sbn = !ub.sign;
		spec_c = 1'b1;
		if (fisd_pkg::is_nan(ua)) begin
			sval_c = fisd_pkg::quiet(ua);
		end else if (fisd_pkg::is_nan(ub)) begin
			sval_c = fisd_pkg::quiet(ub);
		end else if (fisd_pkg::is_inf(ua) && fisd_pkg::is_inf(ub) && (ua.sign != sbn)) begin
			sval_c = fisd_pkg::DEFAULT_NAN;
		end else if (fisd_pkg::is_inf(ua)) begin
			sval_c = a;
		end else if (fisd_pkg::is_inf(ub)) begin
			sval_c = {sbn, fisd_pkg::EXP_MAX, 52'd0};
		end else begin
			sval_c = 64'd0;
			spec_c = 1'b0;
		end
		a_big = a[62:0] >= b[62:0];
		sign_c = a_big ? ua.sign : sbn;
		exp_l  = a_big ? ua.exp : ub.exp;
		frac_l = a_big ? ua.frac : ub.frac;
		exp_s  = a_big ? ub.exp : ua.exp;
		frac_s = a_big ? ub.frac : ua.frac;
		e_l = (exp_l == 11'd0) ? 11'd1 : exp_l;
		e_s = (exp_s == 11'd0) ? 11'd1 : exp_s;
		d = e_l - e_s;
	end

	always_comb begin
		bw = {mb_s1, 3'b000};
		al = bw >> d_s1;
		lost_mask = (56'd1 << d_s1) - 56'd1;
	end

	always_comb begin
		lim = ea_s3 - 11'd1;
		lz = fisd_pkg::clz56(sum_s3[55:0]);
		shamt = (11'(lz) > lim) ? lim[5:0] : lz;
		if (sum_s3[56]) begin
			n_c = {sum_s3[56:2], sum_s3[1] | sum_s3[0]};
			e_c = {1'b0, ea_s3} + 12'd1;
		end else begin
			n_c = sum_s3[55:0] << shamt;
			e_c = {1'b0, ea_s3} - 12'(shamt);
		end
	end

	always_comb begin
		field = n_s4[55] ? e_s4[10:0] : 11'd0;
		rnd = n_s4[2] && (n_s4[1] || n_s4[0] || n_s4[3]);
		mag = {field, n_s4[54:3]} + 63'(rnd);
		if (spec_s4) begin
			res_c = sval_s4;
		end else if (zero_s4) begin
			res_c = {!sub_s4 && sign_s4, 63'd0};
		end else if (e_s4 >= 12'd2047) begin
			res_c = {sign_s4, fisd_pkg::EXP_MAX, 52'd0};
		end else begin
			res_c = {sign_s4, mag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			spec_s1 <= spec_c;
			sval_s1 <= sval_c;
			sign_s1 <= sign_c;
			sub_s1  <= ua.sign ^ sbn;
			side_s1 <= side;
			ea_s1   <= e_l;
			ma_s1   <= {exp_l != 11'd0, frac_l};
			mb_s1   <= {exp_s != 11'd0, frac_s};
			d_s1    <= (d > 11'd63) ? 6'd63 : d[5:0];
		end
		if (rdy_s2) begin
			spec_s2 <= spec_s1;
			sval_s2 <= sval_s1;
			sign_s2 <= sign_s1;
			sub_s2  <= sub_s1;
			side_s2 <= side_s1;
			ea_s2   <= ea_s1;
			ma_s2   <= ma_s1;
			mb_s2   <= {al[55:1], al[0] | (|(bw & lost_mask))};
		end
		if (rdy_s3) begin
			spec_s3 <= spec_s2;
			sval_s3 <= sval_s2;
			sign_s3 <= sign_s2;
			sub_s3  <= sub_s2;
			side_s3 <= side_s2;
			ea_s3   <= ea_s2;
			sum_s3  <= sub_s2 ? ({1'b0, ma_s2, 3'b000} - {1'b0, mb_s2})
				: ({1'b0, ma_s2, 3'b000} + {1'b0, mb_s2});
		end
		if (rdy_s4) begin
			spec_s4 <= spec_s3;
			sval_s4 <= sval_s3;
			sign_s4 <= sign_s3;
			sub_s4  <= sub_s3;
			side_s4 <= side_s3;
			zero_s4 <= sum_s3 == 57'd0;
			n_s4    <= n_c;
			e_s4    <= e_c;
		end
		if (rdy_s5) begin
			res_s5  <= res_c;
			side_s5 <= side_s4;
		end
	end

endmodule

>>> hw/rtl/fisd_chk.sv
// Port-level checker for the reciprocal square root block, bound to the top level.
// Depends on fast_inverse_sqrt_double_macros.svh for the assertion macros.
`include "fast_inverse_sqrt_double_macros.svh"

module fisd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [63:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);
	logic out_nan;

	assign out_nan = (m_axis_tdata[62:52] == 11'h7ff) && (m_axis_tdata[51:0] != 52'd0);

	`FISD_ASSERT_NEXT(a_out_valid_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`FISD_ASSERT_NEXT(a_out_data_held, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`FISD_ASSERT_NOW(a_ready_when_drained, !m_axis_tvalid || m_axis_tready, s_axis_tready)
	`FISD_ASSERT_NOW(a_nan_is_quiet, m_axis_tvalid && out_nan, m_axis_tdata[51])

endmodule

bind fast_inverse_sqrt_double fisd_chk u_chk (.*);
